// File: rtl/bdlp_pkg.sv
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam logic HIGH = 1'b1;

  // Register word offsets (paddr[2])
  localparam logic REG_DEBOUNCE_TIME = 1'b0;
  localparam logic REG_HOLD_TIME     = 1'b1;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        raw_level;
  } in_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic long_press_event;
    logic stable_level;
  } out_t;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] hold_time;
  } cfg_t;

endpackage

// File: rtl/bdlp_cfg.sv
`timescale 1ns / 1ps

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_DEBOUNCE_TIME: cfg_d.debounce_time = pwdata[15:0];
        REG_HOLD_TIME:     cfg_d.hold_time     = pwdata[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE_TIME: prdata = {16'h0000, cfg_q.debounce_time};
      REG_HOLD_TIME:     prdata = {16'h0000, cfg_q.hold_time};
      default:           prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= 16'd50;
      cfg_q.hold_time     <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/bdlp_core.sv
`timescale 1ns / 1ps

module bdlp_core
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  logic                 level_q, level_d;
  logic                 prev_raw_q, prev_raw_d;
  logic [TIME_BITS-1:0] change_time_q, change_time_d;
  logic [TIME_BITS-1:0] press_time_q, press_time_d;
  logic                 long_done_q, long_done_d;
  logic                 press_flag_q, press_flag_d;
  logic                 release_flag_q, release_flag_d;
  logic                 seen_q, seen_d;
  logic [TIME_BITS-1:0] prev_time_q, prev_time_d;

  logic [TIME_BITS-1:0] now;
  logic                 raw;
  logic                 repeat_ts;
  logic                 raw_changed;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_press;
  logic                 flip;
  logic                 press_now;
  logic                 long_evt;

  assign now = TIME_BITS'(item_i.time_ms);
  assign raw = item_i.raw_level;

  assign repeat_ts   = seen_q && (prev_time_q == now);
  assign raw_changed = raw != prev_raw_q;
  // A fresh raw edge restarts the debounce window at this very sample
  assign since_change = raw_changed ? '0 : now - change_time_q;
  assign flip      = !repeat_ts && (since_change >= TIME_BITS'(cfg_i.debounce_time))
                     && (raw != level_q);
  assign press_now = flip && (raw == HIGH);
  // On a fresh press the hold window starts now, so elapsed is zero
  assign since_press = press_now ? '0 : now - press_time_q;

  always_comb begin
    level_d        = level_q;
    prev_raw_d     = prev_raw_q;
    change_time_d  = change_time_q;
    press_time_d   = press_time_q;
    long_done_d    = long_done_q;
    press_flag_d   = press_flag_q;
    release_flag_d = release_flag_q;
    seen_d         = seen_q;
    prev_time_d    = prev_time_q;
    long_evt       = 1'b0;

    if (!repeat_ts) begin
      seen_d         = 1'b1;
      prev_time_d    = now;
      press_flag_d   = 1'b0;
      release_flag_d = 1'b0;
      if (raw_changed) begin
        prev_raw_d    = raw;
        change_time_d = now;
      end
      if (flip) begin
        level_d     = raw;
        long_done_d = 1'b0;
        if (press_now) begin
          press_time_d = now;
          press_flag_d = 1'b1;
        end else begin
          press_time_d   = '0;
          release_flag_d = 1'b1;
        end
      end
    end

    if ((level_d == HIGH) && !long_done_d &&
        (since_press >= TIME_BITS'(cfg_i.hold_time))) begin
      long_done_d = 1'b1;
      long_evt    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q        <= 1'b0;
      prev_raw_q     <= 1'b0;
      change_time_q  <= '0;
      press_time_q   <= '0;
      long_done_q    <= 1'b0;
      press_flag_q   <= 1'b0;
      release_flag_q <= 1'b0;
      seen_q         <= 1'b0;
      prev_time_q    <= '0;
    end else if (en_i) begin
      level_q        <= level_d;
      prev_raw_q     <= prev_raw_d;
      change_time_q  <= change_time_d;
      press_time_q   <= press_time_d;
      long_done_q    <= long_done_d;
      press_flag_q   <= press_flag_d;
      release_flag_q <= release_flag_d;
      seen_q         <= seen_d;
      prev_time_q    <= prev_time_d;
    end
  end

  assign res_o.press_event      = press_flag_d;
  assign res_o.release_event    = release_flag_d;
  assign res_o.long_press_event = long_evt;
  assign res_o.stable_level     = level_d;

endmodule

// File: rtl/button_debounce_long_press_top.sv
`timescale 1ns / 1ps
// Button debouncer with press, release and long-press events.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one pin sample per item,
// a wrapping millisecond timestamp and the raw level. Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result item per sample,
// carrying press, release and long-press events and the debounced level.
// debounce_time (0x0) and hold_time (0x4) are set over the APB port. The user
// must set them only while no item is in flight; the block does not check this.
//
// The sample is captured in the input register, the debounce and hold checks
// run against the state registers, and the result lands in the output
// register. One item per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its item, the input
// register holds the next one, and in_stall_o rises once both are full.
// Reset gives debounce_time 50, hold_time 1000 and a released button seen at
// time 0, with both pipeline registers empty.

module button_debounce_long_press_top
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  cfg_t cfg;
  logic in_valid_q, in_valid_d;
  in_t  in_data_q;
  logic out_valid_q, out_valid_d;
  out_t out_data_q;
  out_t res;
  logic advance;
  logic fire;
  logic in_accept;

  bdlp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdlp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.press_event && out_data_o.release_event))
    else $error("press and release events in one item");

  a_press_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.press_event) |-> out_data_o.stable_level)
    else $error("press event with low stable level");

  a_release_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.release_event) |-> !out_data_o.stable_level)
    else $error("release event with high stable level");

  a_long_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.long_press_event) |-> out_data_o.stable_level)
    else $error("long press event while released");
`endif

endmodule
